>>> sv/svtc_pkg.sv
// Shared types, constants and codes for the scaled virtual time counter.
`default_nettype none

package svtc_pkg;

  localparam int RawW    = 64;
  localparam int VirtW   = 63;
  localparam int FactorW = 16;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 16;
  localparam int CntW    = $clog2(VirtW);

  localparam logic [VirtW-1:0] VMax = '1;

  localparam logic [ModeW-1:0] MODE_PASS     = 2'd0;
  localparam logic [ModeW-1:0] MODE_SPEEDUP  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SLOWDOWN = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_MODE  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DELTA,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_DELTA,
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             is_load;
    logic [ModeW-1:0] mode;
    logic             mul_last;
    logic             div_last;
    logic             out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

>>> sv/svtc_if.sv
// Valid/ready channel interfaces for sample items, results and register writes.
`default_nettype none

interface svtc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [svtc_pkg::RawW-1:0] raw_count;

  modport source (output valid, output command, output raw_count, input ready);
  modport sink   (input valid, input command, input raw_count, output ready);
endinterface

interface svtc_out_if;
  logic                       valid;
  logic                       ready;
  logic [svtc_pkg::VirtW-1:0] virtual_count;

  modport source (output valid, output virtual_count, input ready);
  modport sink   (input valid, input virtual_count, output ready);
endinterface

interface svtc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [svtc_pkg::CfgIdxW-1:0] index;
  logic [svtc_pkg::CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/svtc_ctrl.sv
// Sequencer that steps one item through capture, then a load or delta, scaling and add, then the result beat.
`default_nettype none

module svtc_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire svtc_pkg::ctrl_status_t status_i,
  output svtc_pkg::ctrl_cmd_t    cmd_o
);
  import svtc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // The captured command picks the path; a load finishes at once.
        if (status_i.is_load) state_d = ST_EMIT;
        else state_d = ST_DELTA;
      end
      ST_DELTA: begin
        case (status_i.mode)
          MODE_SPEEDUP:  state_d = ST_MUL;
          MODE_SLOWDOWN: state_d = ST_DIV;
          default:       state_d = ST_ADD;
        endcase
      end
      ST_MUL: begin
        if (status_i.mul_last) state_d = ST_ADD;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_CAPTURE;
      end
      ST_LOAD: begin
        if (status_i.is_load) cmd_o.op = OP_LOAD;
      end
      ST_DELTA: cmd_o.op = OP_DELTA;
      ST_MUL:   cmd_o.op = OP_MUL;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_ADD:   cmd_o.op = OP_ADD;
      ST_EMIT: begin
        if (status_i.out_free) cmd_o.op = OP_EMIT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/svtc_datapath.sv
// Counter state, config registers, serial multiply and divide, and result register.
`default_nettype none

module svtc_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire svtc_pkg::ctrl_cmd_t              cmd_i,
  output svtc_pkg::ctrl_status_t                status_o,
  input  wire                                   in_command_i,
  input  wire signed [svtc_pkg::RawW-1:0]       in_raw_count_i,
  input  wire                                   cfg_valid_i,
  input  wire        [svtc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire        [svtc_pkg::CfgDatW-1:0]    cfg_data_i,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic       [svtc_pkg::VirtW-1:0]      out_count_o
);
  import svtc_pkg::*;

  logic [ModeW-1:0]   mode_q;
  logic [FactorW-1:0] factor_q;
  logic               cmd_q;
  logic [RawW-1:0]    raw_q;
  logic [RawW-1:0]    last_raw_q;
  logic [VirtW-1:0]   vt_q;
  logic [VirtW-1:0]   delta_q;
  logic [VirtW-1:0]   acc_q;
  logic               ovf_q;
  logic [FactorW-1:0] rem_q;
  logic [CntW-1:0]    cnt_q;
  logic [VirtW-1:0]   out_q;
  logic               out_valid_q;

  logic [FactorW-1:0] fac;
  logic               positive;
  logic [RawW-1:0]    cur;
  logic [RawW-1:0]    diff;
  logic [VirtW-1:0]   delta;
  logic [$clog2(FactorW)-1:0] mul_idx;
  logic               mul_bit;
  logic [VirtW+1:0]   mul_sum;
  logic [FactorW:0]   trial;
  logic               div_ge;
  logic [FactorW:0]   trial_sub;
  logic [VirtW-1:0]   scaled;
  logic [VirtW:0]     total_sum;

  assign fac = (factor_q == '0) ? {{(FactorW-1){1'b0}}, 1'b1} : factor_q;

  // A non-positive sample counts as the last one; only forward motion adds time.
  assign positive = (raw_q != '0) && !raw_q[RawW-1];
  assign cur      = positive ? raw_q : last_raw_q;
  assign diff     = cur - last_raw_q;
  assign delta    = (cur > last_raw_q) ? diff[VirtW-1:0] : '0;

  // Multiply walks the factor from its top bit; once past the maximum it stays there.
  // The factor width is a power of two, so counting down from the top bit is an inversion.
  assign mul_idx = ~cnt_q[$clog2(FactorW)-1:0];
  assign mul_bit = fac[mul_idx];
  assign mul_sum = {1'b0, acc_q, 1'b0} + {2'b00, (mul_bit ? delta_q : {VirtW{1'b0}})};

  // Restoring divide: the delta register shifts out dividend bits and in quotient bits.
  assign trial     = {rem_q, delta_q[VirtW-1]};
  assign div_ge    = trial >= {1'b0, fac};
  assign trial_sub = trial - {1'b0, fac};

  always_comb begin
    case (mode_q)
      MODE_SPEEDUP:  scaled = ovf_q ? VMax : acc_q;
      MODE_SLOWDOWN: scaled = delta_q;
      default:       scaled = delta_q;
    endcase
  end

  assign total_sum = {1'b0, vt_q} + {1'b0, scaled};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PASS;
      factor_q <= {{(FactorW-1){1'b0}}, 1'b1};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q   <= cfg_data_i[ModeW-1:0];
        REG_SCALE: factor_q <= cfg_data_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0;
      vt_q       <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          last_raw_q <= raw_q;
          vt_q       <= raw_q[RawW-1] ? VMax : raw_q[VirtW-1:0];
        end
        OP_DELTA: last_raw_q <= cur;
        OP_ADD:   vt_q       <= total_sum[VirtW] ? VMax : total_sum[VirtW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        cmd_q <= in_command_i;
        raw_q <= in_raw_count_i;
      end
      OP_DELTA: begin
        delta_q <= delta;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
        rem_q   <= '0;
        cnt_q   <= '0;
      end
      OP_MUL: begin
        acc_q <= mul_sum[VirtW-1:0];
        if (mul_sum[VirtW+1:VirtW] != 2'b00) ovf_q <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      OP_DIV: begin
        rem_q   <= div_ge ? trial_sub[FactorW-1:0] : trial[FactorW-1:0];
        delta_q <= {delta_q[VirtW-2:0], div_ge};
        cnt_q   <= cnt_q + 1'b1;
      end
      OP_EMIT: out_q <= vt_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.is_load  = (cmd_q == CMD_LOAD);
  assign status_o.mode     = mode_q;
  assign status_o.mul_last = (cnt_q == CntW'(FactorW - 1));
  assign status_o.div_last = (cnt_q == CntW'(VirtW - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_q;

endmodule

`default_nettype wire

>>> sv/scaled_virtual_time_counter_unit.sv
// Top level of the scaled virtual time counter: sequencer plus datapath.
//
//   channel  dir   beat carries                 accepted when
//   in_i     in    command, raw_count           in_i.valid && in_i.ready
//   out_o    out   virtual_count                out_o.valid && out_o.ready
//   cfg_i    in    index, data                  cfg_i.valid (ready held high)
//
// One item is in work at a time. A load goes from capture straight to the result;
// a sample passes through delta and add, in speed-up with 16 multiply steps, one per
// factor bit, and in slow-down with 63 restoring divide steps, one per delta bit.
// Reset clears the counter state and sets mode 0 and factor 1.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and its result is held back until that register frees.
`default_nettype none

module scaled_virtual_time_counter_unit (
  input wire   clk_i,
  input wire   rst_ni,
  svtc_in_if.sink    in_i,
  svtc_out_if.source out_o,
  svtc_cfg_if.sink   cfg_i
);
  import svtc_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_i.ready = 1'b1;

  svtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svtc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_command_i   (in_i.command),
    .in_raw_count_i (in_i.raw_count),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_count_o    (out_o.virtual_count)
  );

endmodule

`default_nettype wire
